// ===== rtl/core/base64_stream_decoder_assert.svh =====
// Assertion macros for the base64 stream decoder RTL, used by the back end.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Property that holds at every rising clock edge outside reset.
`define B64SD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define B64SD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/b64sd_pkg.sv =====
// Package: types, constants and decode function of the base64 stream decoder.
`timescale 1ns / 1ps
package b64sd_pkg;

  localparam int COUNT_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int CMD_DEPTH  = 4;
  localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
  localparam logic [7:0] CHAR_LO_A   = 8'h61;
  localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;

  typedef logic [COUNT_BITS-1:0] count_t;
  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // One queued command: up to three data bytes, then an optional summary.
  typedef struct packed {
    logic [2:0][7:0]    data;
    logic [1:0]         nbytes;
    logic               summary;
    logic [FIELD_W-1:0] chars;
    logic [FIELD_W-1:0] bytes;
  } cmd_t;

  function automatic sextet_t decode_char(logic [7:0] c);
    sextet_t s;
    s.ok  = 1'b1;
    s.val = 6'd0;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      s.val = 6'(c - CHAR_UP_A);
    end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      s.val = 6'(c - CHAR_LO_A + 8'd26);
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      s.val = 6'(c - CHAR_ZERO + 8'd52);
    end else if (c == CHAR_PLUS) begin
      s.val = SEXTET_PLUS;
    end else if (c == CHAR_SLASH) begin
      s.val = SEXTET_SLASH;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

  // Clamp a counter to the 16-bit output field.
  function automatic logic [FIELD_W-1:0] field16(count_t v);
    logic [COUNT_BITS+FIELD_W-1:0] w;
    w = (COUNT_BITS + FIELD_W)'(v);
    if (w > (COUNT_BITS + FIELD_W)'({FIELD_W{1'b1}})) begin
      return {FIELD_W{1'b1}};
    end
    return w[FIELD_W-1:0];
  endfunction

endpackage

// ===== rtl/core/b64sd_if.sv =====
// Stream interfaces of the base64 stream decoder: character beats in, result beats out.
`timescale 1ns / 1ps
interface b64sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_input;

  modport source (output valid, output in_char, output end_of_input, input ready);
  modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

interface b64sd_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic [15:0] chars_consumed;
  logic [15:0] bytes_produced;
  logic        run_last;

  modport source (output valid, output out_kind, output out_byte, output chars_consumed,
                  output bytes_produced, output run_last, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input chars_consumed,
                  input bytes_produced, input run_last, output ready);
endinterface

// ===== rtl/core/b64sd_front.sv =====
// Front end: classifies characters, tracks group and counters, issues commands.
`timescale 1ns / 1ps
module b64sd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  b64sd_in_if.sink         in_i,
  output b64sd_pkg::cmd_t  cmd_o,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i
);
  import b64sd_pkg::*;

  logic [1:0]      fill_q, fill_d, fill_mid;
  logic [2:0][5:0] held_q, held_d, held_mid;
  logic            stopped_q, stopped_d;
  count_t          cc_q, cc_d, cc_next;
  count_t          bp_q, bp_d, bp_next;
  logic [COUNT_BITS:0] bp_sum;
  sextet_t         dec;
  logic            accept, complete, flush, eoi;
  logic [1:0]      nbytes;

  assign in_i.ready = cmd_ready_i;
  assign accept     = in_i.valid && cmd_ready_i;
  assign eoi        = in_i.end_of_input;

  always_comb begin
    dec      = decode_char(in_i.in_char);
    complete = dec.ok && (fill_q == 2'd3);
    held_mid = held_q;
    fill_mid = fill_q;
    if (dec.ok) begin
      if (complete) begin
        fill_mid = 2'd0;
      end else begin
        held_mid[fill_q] = dec.val;
        fill_mid         = fill_q + 2'd1;
      end
    end
    flush   = !dec.ok || eoi;
    cc_next = (dec.ok && cc_q != COUNT_MAX) ? cc_q + count_t'(1) : cc_q;
    if (complete) begin
      nbytes = 2'd3;
    end else if (flush && fill_mid == 2'd3) begin
      nbytes = 2'd2;
    end else if (flush && fill_mid == 2'd2) begin
      nbytes = 2'd1;
    end else begin
      nbytes = 2'd0;
    end
    bp_sum  = {1'b0, bp_q} + (COUNT_BITS + 1)'(nbytes);
    bp_next = (bp_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : bp_sum[COUNT_BITS-1:0];

    cmd_o.data[0] = {held_mid[0], held_mid[1][5:4]};
    cmd_o.data[1] = {held_mid[1][3:0], held_mid[2][5:2]};
    cmd_o.data[2] = {held_mid[2][1:0], dec.val};
    cmd_o.nbytes  = nbytes;
    cmd_o.summary = flush;
    cmd_o.chars   = field16(cc_next);
    cmd_o.bytes   = field16(bp_next);
    cmd_valid_o   = in_i.valid && !stopped_q && (nbytes != 2'd0 || flush);

    fill_d    = fill_q;
    held_d    = held_q;
    stopped_d = stopped_q;
    cc_d      = cc_q;
    bp_d      = bp_q;
    if (accept) begin
      if (stopped_q) begin
        if (eoi) begin
          fill_d    = 2'd0;
          held_d    = '0;
          stopped_d = 1'b0;
          cc_d      = '0;
          bp_d      = '0;
        end
      end else begin
        fill_d = fill_mid;
        held_d = held_mid;
        cc_d   = cc_next;
        bp_d   = bp_next;
        if (flush) begin
          fill_d = 2'd0;
          if (eoi) begin
            held_d = '0;
            cc_d   = '0;
            bp_d   = '0;
          end else begin
            stopped_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= 2'd0;
      held_q    <= '0;
      stopped_q <= 1'b0;
      cc_q      <= '0;
      bp_q      <= '0;
    end else begin
      fill_q    <= fill_d;
      held_q    <= held_d;
      stopped_q <= stopped_d;
      cc_q      <= cc_d;
      bp_q      <= bp_d;
    end
  end

endmodule

// ===== rtl/core/b64sd_cmd_fifo.sv =====
// Short command queue between front end and result sequencer.
`timescale 1ns / 1ps
module b64sd_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  b64sd_pkg::cmd_t  push_cmd_i,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  output b64sd_pkg::cmd_t  head_cmd_o,
  output logic             head_valid_o,
  input  logic             pop_i
);
  import b64sd_pkg::*;

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = (count_q != CMD_CNT_W'(CMD_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + CMD_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + CMD_PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CMD_CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CMD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/core/b64sd_back.sv =====
// Back end: expands each command into result beats through an output register.
`timescale 1ns / 1ps
`include "base64_stream_decoder_assert.svh"
module b64sd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  b64sd_pkg::cmd_t  head_cmd_i,
  input  logic             head_valid_i,
  output logic             pop_o,
  b64sd_out_if.source      out_o
);
  import b64sd_pkg::*;

  logic [1:0]         idx_q, idx_d;
  logic [2:0]         nres;
  logic               last, advance, emit;
  logic               valid_q, valid_d;
  logic               kind_q, kind_d;
  logic [7:0]         byte_q, byte_d;
  logic [FIELD_W-1:0] chars_q, chars_d, bytes_q, bytes_d;
  logic               last_q, last_d;

  always_comb begin
    nres    = {1'b0, head_cmd_i.nbytes} + {2'b00, head_cmd_i.summary};
    last    = ({1'b0, idx_q} == nres - 3'd1);
    advance = !valid_q || out_o.ready;
    emit    = advance && head_valid_i;
    pop_o   = emit && last;

    idx_d   = idx_q;
    valid_d = advance ? head_valid_i : valid_q;
    kind_d  = kind_q;
    byte_d  = byte_q;
    chars_d = chars_q;
    bytes_d = bytes_q;
    last_d  = last_q;
    if (emit) begin
      idx_d  = last ? 2'd0 : idx_q + 2'd1;
      last_d = last;
      if (idx_q < head_cmd_i.nbytes) begin
        kind_d  = 1'b0;
        byte_d  = head_cmd_i.data[idx_q];
        chars_d = '0;
        bytes_d = '0;
      end else begin
        kind_d  = 1'b1;
        byte_d  = 8'd0;
        chars_d = head_cmd_i.chars;
        bytes_d = head_cmd_i.bytes;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    byte_q  <= byte_d;
    chars_q <= chars_d;
    bytes_q <= bytes_d;
    last_q  <= last_d;
  end

  assign out_o.valid          = valid_q;
  assign out_o.out_kind       = kind_q;
  assign out_o.out_byte       = byte_q;
  assign out_o.chars_consumed = chars_q;
  assign out_o.bytes_produced = bytes_q;
  assign out_o.run_last       = last_q;

  `B64SD_ASSERT(a_summary_is_last, clk_i, rst_ni, !(valid_q && kind_q) || last_q, "summary beat without run_last")
  `B64SD_ASSERT(a_data_no_counts, clk_i, rst_ni, !(valid_q && !kind_q) || (chars_q == '0 && bytes_q == '0), "data beat carries counts")
  `B64SD_ASSERT(a_mid_cmd_head, clk_i, rst_ni, (idx_q == 2'd0) || head_valid_i, "command lost mid-expansion")
  `B64SD_ASSERT_NEXT(a_partial_holds, clk_i, rst_ni, emit && !last, idx_q == $past(idx_q) + 2'd1, "result index did not step")

endmodule

// ===== rtl/core/base64_stream_decoder.sv =====
// Path: an accepted character's command passes the command queue, then the output register.
// Throughput: one character beat per cycle while the 4-entry command queue has room; results
//   leave one beat per cycle while ready is high, 0 to 4 per item (3 per 4 chars on average).
// Reset: asynchronous, active low; clears group, stop flag, counters, queue and output valid.
`timescale 1ns / 1ps
module base64_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64sd_in_if.sink    in_i,
  b64sd_out_if.source out_o
);
  import b64sd_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic push_valid, push_ready, head_valid, pop;

  b64sd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (push_cmd),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready)
  );

  b64sd_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cmd_i   (push_cmd),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .head_cmd_o   (head_cmd),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  b64sd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_cmd_i   (head_cmd),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

// ===== dv/tb.sv =====
// Testbench for the base64 stream decoder: directed table, then random streams.
`timescale 1ns / 1ps
module tb;
  import b64sd_pkg::*;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam int         IDLE_LIMIT = 5000;
  localparam int         HOLD_LEN   = 300;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [15:0] chars;
    logic [15:0] nbytes;
    logic        last;
  } beat_t;

  typedef struct packed {
    logic [7:0]      ch;
    logic            eoi;
    logic            typed;
    logic [2:0]      n_typed;
    beat_t [3:0]     want;
  } stim_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  b64sd_in_if  in_bus ();
  b64sd_out_if out_bus ();

  base64_stream_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  always #5 clk_i = ~clk_i;

  // decoder state mirror
  logic [1:0] grp_fill;
  logic [5:0] grp_held [3];
  logic       dec_stopped;
  count_t     n_consumed;
  count_t     n_produced;

  stim_t    stim_q [$];
  stim_t    cur;
  beat_t    pending_beats [$];
  beat_t    step_res [$];
  logic     in_fire = 1'b0;
  int       errors = 0;
  int       gap_max = 3;
  int       burst_max = 4;
  int       hold_req = 0;
  rx_mode_e rx_mode = RX_RANDOM;

  function automatic beat_t data_beat(logic [7:0] b, logic last);
    beat_t r;
    r = '0;
    r.data = b;
    r.last = last;
    return r;
  endfunction

  function automatic beat_t summary_beat(logic [15:0] chars, logic [15:0] nbytes);
    beat_t r;
    r = '0;
    r.kind = 1'b1;
    r.chars = chars;
    r.nbytes = nbytes;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic stim_t plain_row(logic [7:0] ch, logic eoi);
    stim_t s;
    s = '0;
    s.ch = ch;
    s.eoi = eoi;
    return s;
  endfunction

  function automatic stim_t fixed_row(logic [7:0] ch, logic eoi, int n,
                                      beat_t w0 = '0, beat_t w1 = '0,
                                      beat_t w2 = '0, beat_t w3 = '0);
    stim_t s;
    s = plain_row(ch, eoi);
    s.typed = 1'b1;
    s.n_typed = 3'(n);
    s.want[0] = w0;
    s.want[1] = w1;
    s.want[2] = w2;
    s.want[3] = w3;
    return s;
  endfunction

  function automatic void add_row(stim_t s);
    stim_q.insert(stim_q.size(), s);
  endfunction

  function automatic bit alpha_value(logic [7:0] c, output logic [5:0] v);
    v = '0;
    if (c inside {[CHAR_UP_A:CHAR_UP_Z]}) v = 6'(c - CHAR_UP_A);
    else if (c inside {[CHAR_LO_A:CHAR_LO_Z]}) v = 6'(c - CHAR_LO_A) + 6'd26;
    else if (c inside {[CHAR_ZERO:CHAR_NINE]}) v = 6'(c - CHAR_ZERO) + 6'd52;
    else if (c == CHAR_PLUS) v = SEXTET_PLUS;
    else if (c == CHAR_SLASH) v = SEXTET_SLASH;
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] sextet_char(int k);
    if (k < 26) return CHAR_UP_A + 8'(k);
    if (k < 52) return CHAR_LO_A + 8'(k - 26);
    if (k < 62) return CHAR_ZERO + 8'(k - 52);
    if (k == 62) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  function automatic logic [7:0] rand_alpha();
    return sextet_char($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] rand_bad_char();
    logic [7:0] c;
    logic [5:0] v;
    c = 8'($urandom_range(0, 255));
    while (alpha_value(c, v)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic count_t bump(count_t v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] clamp16(count_t v);
    return (64'(v) > 64'hFFFF) ? 16'hFFFF : 16'(v);
  endfunction

  function automatic void restart_stream();
    grp_fill = '0;
    grp_held = '{default: '0};
    dec_stopped = 1'b0;
    n_consumed = '0;
    n_produced = '0;
  endfunction

  function automatic void emit_byte(ref beat_t res[$], input logic [7:0] b);
    n_produced = bump(n_produced);
    res.insert(res.size(), data_beat(b, 1'b0));
  endfunction

  task automatic decode_beat(input logic [7:0] ch, input logic eoi, ref beat_t res[$]);
    logic [5:0] v;
    logic       ok;
    res.delete();
    if (dec_stopped) begin
      if (eoi) restart_stream();
      return;
    end
    ok = alpha_value(ch, v);
    if (ok) begin
      n_consumed = bump(n_consumed);
      if (grp_fill == 2'd3) begin
        emit_byte(res, {grp_held[0], grp_held[1][5:4]});
        emit_byte(res, {grp_held[1][3:0], grp_held[2][5:2]});
        emit_byte(res, {grp_held[2][1:0], v});
        grp_fill = '0;
      end else begin
        grp_held[grp_fill] = v;
        grp_fill = grp_fill + 2'd1;
      end
    end
    if (!ok || eoi) begin
      if (grp_fill >= 2'd2) emit_byte(res, {grp_held[0], grp_held[1][5:4]});
      if (grp_fill == 2'd3) emit_byte(res, {grp_held[1][3:0], grp_held[2][5:2]});
      res.insert(res.size(), summary_beat(clamp16(n_consumed), clamp16(n_produced)));
      grp_fill = '0;
      if (eoi) restart_stream();
      else dec_stopped = 1'b1;
    end
    foreach (res[i]) res[i].last = (i == res.size() - 1);
  endtask

  task automatic flag(string what, beat_t want, beat_t got);
    if (errors < 10) begin
      $display("%0t %s: want kind=%0d byte=%02h chars=%0d bytes=%0d last=%0d", $realtime,
               what, want.kind, want.data, want.chars, want.nbytes, want.last);
      $display("%0t %s: got  kind=%0d byte=%02h chars=%0d bytes=%0d last=%0d", $realtime,
               what, got.kind, got.data, got.chars, got.nbytes, got.last);
    end
    errors++;
  endtask

  // One stream: valid characters, then one of the ways a stream can end.
  task automatic queue_stream(output int n);
    int len;
    int sel;
    int junk;
    int start;
    start = stim_q.size();
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 30);
    for (int i = 0; i < len; i++) add_row(plain_row(rand_alpha(), 1'b0));
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      if (len > 0) stim_q[stim_q.size() - 1].eoi = 1'b1;
      else add_row(plain_row(rand_alpha(), 1'b1));
    end else if (sel < 85) begin
      if (sel < 65) begin
        add_row(plain_row(PAD_CHAR, 1'b0));
        if ($urandom_range(0, 1)) add_row(plain_row(PAD_CHAR, 1'b0));
      end else begin
        add_row(plain_row(rand_bad_char(), 1'b0));
      end
      junk = $urandom_range(0, 3);
      for (int i = 0; i < junk; i++)
        add_row(plain_row(8'($urandom_range(0, 255)), 1'b0));
      add_row(plain_row(8'($urandom_range(0, 255)), 1'b1));
    end else if (sel < 93) begin
      add_row(plain_row(rand_bad_char(), 1'b1));
    end else begin
      junk = $urandom_range(1, 6);
      for (int i = 0; i < junk; i++)
        add_row(plain_row(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0));
      add_row(plain_row(8'($urandom_range(0, 255)), 1'b1));
    end
    n = stim_q.size() - start;
  endtask

  task automatic queue_streams(input int target);
    int got;
    int n;
    got = 0;
    while (got < target) begin
      queue_stream(n);
      got += n;
    end
  endtask

  task automatic wait_sent();
    while (stim_q.size() != 0) @(posedge clk_i);
  endtask

  // input side: bursts and gaps
  initial begin
    int burst_left;
    int gap_left;
    burst_left = 1;
    gap_left = 0;
    cur = '0;
    in_bus.valid = 1'b0;
    in_bus.in_char = '0;
    in_bus.end_of_input = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!(in_bus.valid && !in_fire)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid = 1'b0;
        end else if (rst_ni && stim_q.size() != 0) begin
          cur = stim_q.pop_front();
          in_bus.in_char = cur.ch;
          in_bus.end_of_input = cur.eoi;
          in_bus.valid = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap_left = $urandom_range(0, gap_max);
          end
        end else begin
          in_bus.valid = 1'b0;
        end
      end
    end
  end

  // result side: always ready, random or patterned stalls, plus long hold-off on request
  initial begin
    int          hold_left;
    logic [12:0] rx_mask;
    hold_left = 0;
    rx_mask = 13'b1101_1001_1011_1;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_bus.ready = 1'b1;
          RX_RANDOM: out_bus.ready = ($urandom_range(0, 99) >= 35);
          default: begin
            out_bus.ready = rx_mask[0];
            rx_mask = {rx_mask[0], rx_mask[12:1]};
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    beat_t got;
    beat_t want;
    if (!rst_ni) begin
      in_fire = 1'b0;
    end else begin
      in_fire = in_bus.valid && in_bus.ready;
      if (in_fire) begin
        decode_beat(in_bus.in_char, in_bus.end_of_input, step_res);
        if (cur.typed) begin
          for (int i = 0; i < cur.n_typed; i++)
            pending_beats.insert(pending_beats.size(), cur.want[i]);
        end else begin
          foreach (step_res[i]) pending_beats.insert(pending_beats.size(), step_res[i]);
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.out_kind, out_bus.out_byte, out_bus.chars_consumed,
                out_bus.bytes_produced, out_bus.run_last};
        if (pending_beats.size() == 0) begin
          flag("unexpected beat", '0, got);
        end else begin
          want = pending_beats.pop_front();
          if (got.kind !== want.kind || got.data !== want.data || got.chars !== want.chars ||
              got.nbytes !== want.nbytes || got.last !== want.last)
            flag("mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    int idle;
    if (!rst_ni) begin
      idle = 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle = 0;
    end else begin
      idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d beats outstanding", idle,
                 pending_beats.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    stim_t dir_rows [$];
    restart_stream();
    dir_rows = '{
      fixed_row(PAD_CHAR, 1'b0, 1, summary_beat(16'd0, 16'd0)),
      fixed_row("Q", 1'b1, 0),
      fixed_row("A", 1'b0, 0),
      fixed_row("A", 1'b0, 0),
      fixed_row("A", 1'b0, 0),
      fixed_row("A", 1'b0, 3, data_beat(8'h00, 1'b0), data_beat(8'h00, 1'b0),
                data_beat(8'h00, 1'b1)),
      fixed_row("/", 1'b0, 0),
      fixed_row("/", 1'b0, 0),
      fixed_row("/", 1'b0, 0),
      fixed_row("/", 1'b1, 4, data_beat(8'hFF, 1'b0), data_beat(8'hFF, 1'b0),
                data_beat(8'hFF, 1'b0), summary_beat(16'd8, 16'd6)),
      plain_row("T", 1'b0),
      plain_row("Q", 1'b0),
      plain_row(PAD_CHAR, 1'b0),
      fixed_row(PAD_CHAR, 1'b0, 0),
      fixed_row(8'hFF, 1'b1, 0),
      fixed_row("z", 1'b0, 0),
      fixed_row("!", 1'b0, 1, summary_beat(16'd1, 16'd0)),
      fixed_row(8'h00, 1'b1, 0),
      plain_row("Z", 1'b0),
      plain_row("0", 1'b0),
      plain_row("+", 1'b1),
      fixed_row(8'h00, 1'b1, 1, summary_beat(16'd0, 16'd0)),
      fixed_row("9", 1'b0, 0),
      fixed_row("@", 1'b1, 1, summary_beat(16'd1, 16'd0)),
      fixed_row(8'hFF, 1'b0, 1, summary_beat(16'd0, 16'd0)),
      fixed_row(8'h80, 1'b1, 0)
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) add_row(dir_rows[i]);
    wait_sent();

    gap_max = 6;
    burst_max = 12;
    queue_streams(120);
    wait_sent();

    // no idling on either side
    rx_mode = RX_ALWAYS;
    gap_max = 0;
    burst_max = 64;
    queue_streams(90);
    wait_sent();

    // receiver holds off while the sender keeps offering
    hold_req = HOLD_LEN;
    queue_streams(80);
    wait_sent();

    rx_mode = RX_PATTERN;
    gap_max = 4;
    burst_max = 8;
    queue_streams(110);

    while (stim_q.size() != 0 || in_bus.valid || pending_beats.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    errors += pending_beats.size();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/b64sd_pkg.sv
rtl/core/b64sd_if.sv
rtl/core/b64sd_front.sv
rtl/core/b64sd_cmd_fifo.sv
rtl/core/b64sd_back.sv
rtl/core/base64_stream_decoder.sv
dv/tb.sv
